/* design/hts_pkg.sv */
// hts_pkg: shared types and constants of the heightmap triangle sampler
// payload structs, classification flags, opcodes, register indexes, queue depths
// no dependencies
package hts_pkg;

  typedef struct packed {
    logic        op;
    logic [7:0]  write_col;
    logic [7:0]  write_row;
    logic [15:0] write_height;
    logic [15:0] query_x;
    logic [15:0] query_z;
  } hts_in_t;

  typedef struct packed {
    logic [23:0] height;
    logic        in_range;
  } hts_out_t;

  // flags worked out by the front end for one beat
  typedef struct packed {
    logic is_query;
    logic write_ok;
    logic in_range;
    logic last_col;
    logic last_row;
  } hts_cls_t;

  typedef struct packed {
    hts_cls_t cls;
    hts_in_t  item;
  } hts_cmd_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_MAP_WIDTH = 1'b0;
  localparam logic REG_MAP_DEPTH = 1'b1;

  localparam int          CFG_W     = 9;
  localparam logic [8:0]  DIM_RESET = 9'd256;
  localparam int          OUT_W     = 24;
  localparam logic [23:0] OUT_MAX   = 24'hFFFFFF;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

endpackage

/* design/hts_ram.sv */
// hts_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module hts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* design/hts_fifo.sv */
// hts_fifo: small register queue with occupancy count
// used between front and back end and as the result queue; no dependencies
module hts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

/* design/hts_front.sv */
// hts_front: classifies an incoming beat (write or query, range, edge cells)
// depends on hts_pkg
module hts_front #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_DEPTH = 256,
  parameter int FRAC_BITS = 8
) (
  input  hts_pkg::hts_in_t                    item,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_lim,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]      depth_lim,
  output hts_pkg::hts_cls_t                   cls
);
  import hts_pkg::*;

  localparam int QIW = 16 - FRAC_BITS;

  logic [QIW-1:0] xi, zi;

  always_comb begin
    xi           = QIW'(item.query_x >> FRAC_BITS);
    zi           = QIW'(item.query_z >> FRAC_BITS);
    cls.is_query = item.op == OP_QUERY;
    cls.write_ok = (32'(item.write_col) < MAX_WIDTH) && (32'(item.write_row) < MAX_DEPTH);
    cls.in_range = (32'(xi) < 32'(width_lim)) && (32'(zi) < 32'(depth_lim));
    cls.last_col = (32'(xi) + 32'd1) == 32'(width_lim);
    cls.last_row = (32'(zi) + 32'd1) == 32'(depth_lim);
  end

endmodule

/* design/hts_back.sv */
// hts_back: parity-banked sample store, corner fetch, triangle fixup, interpolation
// and result queue; depends on hts_pkg, hts_ram, hts_fifo
module hts_back #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_DEPTH   = 256,
  parameter int FRAC_BITS   = 8,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  hts_pkg::hts_cmd_t cmd_data,
  output logic              cmd_pop,
  output logic              out_empty,
  output hts_pkg::hts_out_t out_data,
  input  logic              out_pop
);
  import hts_pkg::*;

  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int RIW = $clog2(MAX_DEPTH);
  localparam int CHW = (CIW > 1) ? CIW - 1 : 1;
  localparam int RHW = (RIW > 1) ? RIW - 1 : 1;
  localparam int BAW = CHW + RHW;
  localparam int CW  = HEIGHT_BITS + 2;
  localparam int PW  = CW + FRAC_BITS + 3;
  localparam int AW  = PW + FRAC_BITS + 3;
  localparam int SW  = (AW - FRAC_BITS > OUT_W + 1) ? AW - FRAC_BITS : OUT_W + 1;
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam logic [FRAC_BITS:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

  // issue stage
  logic                   credit_ok, wr_fire, is_query;
  logic [2:0]             inflight;
  logic [CIW-1:0]         hx;
  logic [RIW-1:0]         hz;
  logic [CIW:0]           xp1;
  logic [RIW:0]           zp1;
  logic [BAW-1:0]         wr_addr;
  logic [HEIGHT_BITS-1:0] wr_data;
  logic [3:0]             bank_we;
  logic [BAW-1:0]         bank_raddr [4];
  logic [HEIGHT_BITS-1:0] bank_rdata [4];

  // pipeline registers
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                 s1_inr_r, s2_inr_r, s3_inr_r, s4_inr_r;
  logic                 s1_px_r, s1_pz_r, s1_lc_r, s1_lr_r;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fz_r, s2_fx_r, s2_fz_r, s3_fz_r;
  logic signed [CW-1:0] s2_tl_r, s2_tr_r, s2_bl_r, s2_br_r;
  logic signed [PW-1:0] s3_top_r, s3_bot_r;
  logic signed [AW-1:0] s4_acc_r;

  logic signed [CW-1:0] tl_nxt, tr_nxt, bl_nxt, br_nxt;
  logic signed [PW-1:0] top_nxt, bot_nxt;
  logic signed [AW-1:0] acc_nxt;
  logic [1:0]           i_bl, i_br, i_tl, i_tr;
  logic [FRAC_BITS:0]   wx0, wz0;
  logic [SW-1:0]        sh;
  hts_out_t             res;
  logic                 out_full;
  logic [OCW-1:0]       out_count;

  assign inflight  = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r) + 3'(s4_v_r);
  assign credit_ok = (32'(out_count) + 32'(inflight)) < OUT_DEPTH;
  assign is_query  = cmd_data.cls.is_query;
  assign cmd_pop   = !cmd_empty && (!is_query || credit_ok);
  assign wr_fire   = cmd_pop && !is_query && cmd_data.cls.write_ok;

  always_comb begin
    hx      = CIW'(cmd_data.item.query_x >> FRAC_BITS);
    hz      = RIW'(cmd_data.item.query_z >> FRAC_BITS);
    xp1     = (CIW+1)'(hx) + (CIW+1)'(1);
    zp1     = (RIW+1)'(hz) + (RIW+1)'(1);
    wr_addr = {RHW'(cmd_data.item.write_row >> 1), CHW'(cmd_data.item.write_col >> 1)};
    wr_data = HEIGHT_BITS'(cmd_data.item.write_height);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BID = 2'(b);
    assign bank_we[b] = wr_fire &&
                        ({cmd_data.item.write_row[0], cmd_data.item.write_col[0]} == BID);
    // even banks take the next cell when the query sits on an odd index
    assign bank_raddr[b] = {BID[1] ? RHW'(hz >> 1) : zp1[RHW:1],
                            BID[0] ? CHW'(hx >> 1) : xp1[CHW:1]};
    hts_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (2**BAW)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // corner select and triangle fixup
  always_comb begin
    i_bl   = {s1_pz_r, s1_px_r};
    i_br   = {s1_pz_r, s1_lc_r ? s1_px_r : ~s1_px_r};
    i_tl   = {s1_lr_r ? s1_pz_r : ~s1_pz_r, s1_px_r};
    i_tr   = {s1_lr_r ? s1_pz_r : ~s1_pz_r, s1_lc_r ? s1_px_r : ~s1_px_r};
    bl_nxt = $signed({2'b00, bank_rdata[i_bl]});
    br_nxt = $signed({2'b00, bank_rdata[i_br]});
    tl_nxt = $signed({2'b00, bank_rdata[i_tl]});
    tr_nxt = $signed({2'b00, bank_rdata[i_tr]});
    if (s1_pz_r) begin
      if (s1_fz_r >= s1_fx_r) begin
        br_nxt = bl_nxt + tr_nxt - tl_nxt;
      end else begin
        tl_nxt = tr_nxt + bl_nxt - br_nxt;
      end
    end else begin
      if (({1'b0, s1_fx_r} + {1'b0, s1_fz_r}) < ONE_FRAC) begin
        tr_nxt = tl_nxt + br_nxt - bl_nxt;
      end else begin
        bl_nxt = tl_nxt + br_nxt - tr_nxt;
      end
    end
  end

  // horizontal blend
  always_comb begin
    wx0     = ONE_FRAC - {1'b0, s2_fx_r};
    top_nxt = PW'(s2_tl_r) * PW'($signed({1'b0, wx0}))
            + PW'(s2_tr_r) * PW'($signed({2'b00, s2_fx_r}));
    bot_nxt = PW'(s2_bl_r) * PW'($signed({1'b0, wx0}))
            + PW'(s2_br_r) * PW'($signed({2'b00, s2_fx_r}));
  end

  // vertical blend
  always_comb begin
    wz0     = ONE_FRAC - {1'b0, s3_fz_r};
    acc_nxt = AW'(s3_bot_r) * AW'($signed({1'b0, wz0}))
            + AW'(s3_top_r) * AW'($signed({2'b00, s3_fz_r}));
  end

  // truncate and saturate
  always_comb begin
    sh           = SW'(s4_acc_r[AW-1:FRAC_BITS]);
    res.in_range = s4_inr_r;
    if (!s4_inr_r || s4_acc_r <= 0) begin
      res.height = '0;
    end else if (sh > SW'(OUT_MAX)) begin
      res.height = OUT_MAX;
    end else begin
      res.height = sh[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd_pop && is_query;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_inr_r <= cmd_data.cls.in_range;
    s1_lc_r  <= cmd_data.cls.last_col;
    s1_lr_r  <= cmd_data.cls.last_row;
    s1_px_r  <= hx[0];
    s1_pz_r  <= hz[0];
    s1_fx_r  <= cmd_data.item.query_x[FRAC_BITS-1:0];
    s1_fz_r  <= cmd_data.item.query_z[FRAC_BITS-1:0];
    s2_inr_r <= s1_inr_r;
    s2_fx_r  <= s1_fx_r;
    s2_fz_r  <= s1_fz_r;
    s2_tl_r  <= tl_nxt;
    s2_tr_r  <= tr_nxt;
    s2_bl_r  <= bl_nxt;
    s2_br_r  <= br_nxt;
    s3_inr_r <= s2_inr_r;
    s3_fz_r  <= s2_fz_r;
    s3_top_r <= top_nxt;
    s3_bot_r <= bot_nxt;
    s4_inr_r <= s3_inr_r;
    s4_acc_r <= acc_nxt;
  end

  hts_fifo #(
    .WIDTH ($bits(hts_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s4_v_r),
    .wdata (res),
    .pop   (out_pop),
    .rdata (out_data),
    .full  (out_full),
    .empty (out_empty),
    .count (out_count)
  );

  a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> !out_full)
    else $error("result beat arrived at a full result queue");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(out_count) + 32'(inflight)) <= OUT_DEPTH)
    else $error("queries in flight exceed result queue room");

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one bank written in a cycle");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("query dropped between fetch and blend");

endmodule

/* design/heightmap_triangle_sampler.sv */
// heightmap_triangle_sampler: top level with config registers, front end, command queue
// and back end; depends on hts_pkg, hts_front, hts_fifo, hts_back
//
// Heightmap sampler. Write beats (op 0) store one 16-bit sample at (write_col, write_row);
// query beats (op 1) give an 8.8 position and return one result beat with the height
// interpolated over the triangle-split cell (diagonal alternating by row parity), 8 fraction
// bits, truncated and saturated to 24 bits; outside the grid the height is 0 and in_range 0.
// map_width (0x0) and map_depth (0x4) set the grid in use, clamped to 2..MAX_WIDTH/MAX_DEPTH.
// Throughput is one beat per clock, writes and queries mixed, while the result queue has room
// for every query in flight: samples live in four banks split by column and row parity, so the
// four corners of a cell come from four read ports at once. A query's result passes through
// fetch, fixup, two multiply stages and the result queue on its way to the output. No clearing
// pass: a sample must be written before a query reads it.
module heightmap_triangle_sampler #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_DEPTH   = 256,
  parameter int FRAC_BITS   = 8,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  hts_pkg::hts_in_t  in_data,
  output logic              empty,
  input  logic              pop,
  output hts_pkg::hts_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hts_pkg::*;

  localparam int DWW = $clog2(MAX_WIDTH + 1);
  localparam int DDW = $clog2(MAX_DEPTH + 1);

  logic [CFG_W-1:0] map_width_r, map_depth_r;
  logic [DWW-1:0]   width_lim;
  logic [DDW-1:0]   depth_lim;
  logic             cfg_wr;
  hts_cls_t         cls;
  hts_cmd_t         cmd_in, cmd_head;
  logic             cmd_empty, cmd_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAP_DEPTH) ? 32'(map_depth_r) : 32'(map_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= DIM_RESET;
      map_depth_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAP_WIDTH: map_width_r <= pwdata[CFG_W-1:0];
        REG_MAP_DEPTH: map_depth_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_width_r < CFG_W'(2)) begin
      width_lim = DWW'(2);
    end else if (32'(map_width_r) > MAX_WIDTH) begin
      width_lim = DWW'(MAX_WIDTH);
    end else begin
      width_lim = DWW'(map_width_r);
    end
    if (map_depth_r < CFG_W'(2)) begin
      depth_lim = DDW'(2);
    end else if (32'(map_depth_r) > MAX_DEPTH) begin
      depth_lim = DDW'(MAX_DEPTH);
    end else begin
      depth_lim = DDW'(map_depth_r);
    end
  end

  hts_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DEPTH (MAX_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .item      (in_data),
    .width_lim (width_lim),
    .depth_lim (depth_lim),
    .cls       (cls)
  );

  assign cmd_in.cls  = cls;
  assign cmd_in.item = in_data;

  hts_fifo #(
    .WIDTH ($bits(hts_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .full  (full),
    .empty (cmd_empty),
    .count ()
  );

  hts_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_DEPTH   (MAX_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_empty (empty),
    .out_data  (out_data),
    .out_pop   (pop)
  );

endmodule

/* tb/heightmap_triangle_sampler_tb.sv */
// heightmap_triangle_sampler_tb: self-checking testbench for the heightmap triangle sampler
// drives sample writes and height queries through the queue ports and the APB config port,
// predicts each query result in place; depends on hts_pkg and heightmap_triangle_sampler
`timescale 1ns / 1ps

module heightmap_triangle_sampler_tb;
  import hts_pkg::*;

  localparam int          GRID_COLS = 256;
  localparam int          GRID_ROWS = 256;
  localparam int          FRAC      = 8;
  localparam longint      ONE_POS   = 256;
  localparam int          SETTLE    = 12;
  localparam int unsigned LIMIT     = 1000000;

  logic        clk;
  logic        rst_n   = 1'b0;
  logic        push    = 1'b0;
  logic        full;
  hts_in_t     in_data = '0;
  logic        empty;
  logic        pop     = 1'b0;
  hts_out_t    out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  heightmap_triangle_sampler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the block state
  bit   [15:0] grid_heights [0:GRID_COLS*GRID_ROWS-1];
  bit          grid_written [0:GRID_COLS*GRID_ROWS-1];
  logic [8:0]  cfg_width = DIM_RESET;
  logic [8:0]  cfg_depth = DIM_RESET;

  hts_out_t    expected_results [$];
  hts_out_t    want;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 80;
  int unsigned hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: height %0h in_range %0b",
               out_data.height, out_data.in_range);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.height !== want.height) begin
          $error("height: expected %0h, got %0h", want.height, out_data.height);
          error_count++;
        end
        if (out_data.in_range !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, out_data.in_range);
          error_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_dim(logic [8:0] v, int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic hts_out_t predict_height(hts_in_t it);
    int unsigned w, d, x, z, x1, z1;
    longint      fx, fz, bl, br, tl, tr, top, bot, acc;
    hts_out_t    r;
    r = '0;
    w = eff_dim(cfg_width, GRID_COLS);
    d = eff_dim(cfg_depth, GRID_ROWS);
    x = it.query_x >> FRAC;
    z = it.query_z >> FRAC;
    if (x >= w || z >= d) return r;
    fx = it.query_x[FRAC-1:0];
    fz = it.query_z[FRAC-1:0];
    x1 = (x + 1 >= w) ? x : x + 1;
    z1 = (z + 1 >= d) ? z : z + 1;
    bl = grid_heights[z * GRID_COLS + x];
    br = grid_heights[z * GRID_COLS + x1];
    tl = grid_heights[z1 * GRID_COLS + x];
    tr = grid_heights[z1 * GRID_COLS + x1];
    if (z % 2 == 1) begin
      if (fz >= fx) br = bl + (tr - tl);
      else tl = tr + (bl - br);
    end else begin
      if (fx + fz < ONE_POS) tr = tl + (br - bl);
      else bl = tl + (br - tr);
    end
    top = tl * (ONE_POS - fx) + tr * fx;
    bot = bl * (ONE_POS - fx) + br * fx;
    acc = bot * (ONE_POS - fz) + top * fz;
    if (acc > 0) begin
      acc = acc >>> FRAC;
      r.height = (acc > longint'(OUT_MAX)) ? OUT_MAX : acc[23:0];
    end
    r.in_range = 1'b1;
    return r;
  endfunction

  task automatic send_beat(input hts_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (it.op == OP_QUERY) begin
      expected_results.push_back(predict_height(it));
    end else begin
      grid_heights[it.write_row * GRID_COLS + it.write_col] = it.write_height;
      grid_written[it.write_row * GRID_COLS + it.write_col] = 1'b1;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAP_WIDTH) cfg_width = value[8:0];
    else cfg_depth = value[8:0];
    @(posedge clk);
  endtask

  task automatic store_sample(input int unsigned col, input int unsigned row,
                              input logic [15:0] h);
    hts_in_t it;
    it.op           = OP_WRITE;
    it.write_col    = col[7:0];
    it.write_row    = row[7:0];
    it.write_height = h;
    it.query_x      = 16'($urandom);
    it.query_z      = 16'($urandom);
    send_beat(it);
  endtask

  task automatic fill_sample(input int unsigned col, input int unsigned row);
    if (!grid_written[row * GRID_COLS + col])
      store_sample(col, row, 16'($urandom_range(16'hFFFF)));
  endtask

  // writes any corner still unwritten, then sends the query
  task automatic query_at(input logic [15:0] qx, input logic [15:0] qz);
    int unsigned w, d, x, z, x1, z1;
    hts_in_t     it;
    w = eff_dim(cfg_width, GRID_COLS);
    d = eff_dim(cfg_depth, GRID_ROWS);
    x = qx >> FRAC;
    z = qz >> FRAC;
    if (x < w && z < d) begin
      x1 = (x + 1 >= w) ? x : x + 1;
      z1 = (z + 1 >= d) ? z : z + 1;
      fill_sample(x, z);
      fill_sample(x1, z);
      fill_sample(x, z1);
      fill_sample(x1, z1);
    end
    it.op           = OP_QUERY;
    it.write_col    = 8'($urandom);
    it.write_row    = 8'($urandom);
    it.write_height = 16'($urandom);
    it.query_x      = qx;
    it.query_z      = qz;
    send_beat(it);
  endtask

  function automatic int unsigned pick_coord(int unsigned lim);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range((lim < 12 ? lim : 12) - 1, 0);
    if (k < 82) return lim - 1;
    if (k < 88) return 0;
    return $urandom_range(lim - 1, 0);
  endfunction

  function automatic logic [7:0] pick_frac();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 15) return 8'h00;
    if (k < 30) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_directed();
    store_sample(0, 0, 16'h0000);
    store_sample(255, 255, 16'hFFFF);
    store_sample(10, 20, 16'h0000);
    store_sample(11, 20, 16'hFFFF);
    store_sample(10, 21, 16'hFFFF);
    store_sample(11, 21, 16'h0000);
    // even row, both triangles; the upper one uses an extrapolated corner
    query_at({8'd10, 8'd1}, {8'd20, 8'd255});
    query_at({8'd10, 8'd0}, {8'd20, 8'd0});
    query_at({8'd10, 8'd100}, {8'd20, 8'd50});
    query_at({8'd10, 8'd200}, {8'd20, 8'd200});
    // odd row, both sides of the diagonal
    query_at({8'd10, 8'd30}, {8'd21, 8'd30});
    query_at({8'd10, 8'd200}, {8'd21, 8'd10});
    query_at({8'd10, 8'd5}, {8'd21, 8'd250});
    // last column and row, then the origin
    query_at(16'hFFFF, 16'hFFFF);
    query_at(16'hFF00, 16'h0080);
    query_at(16'h0000, 16'hFFFF);
    query_at(16'h0000, 16'h0000);
    wait_idle();
  endtask

  task automatic test_config();
    int unsigned widths [6] = '{2, 0, 511, 256, 3, 256};
    int unsigned depths [6] = '{2, 1, 300, 2, 256, 256};
    int unsigned w, d;
    for (int i = 0; i < 6; i++) begin
      wait_idle();
      cfg_write(REG_MAP_WIDTH, widths[i]);
      cfg_write(REG_MAP_DEPTH, depths[i]);
      w = eff_dim(cfg_width, GRID_COLS);
      d = eff_dim(cfg_depth, GRID_ROWS);
      query_at(16'h0000, 16'h0000);
      query_at({w[7:0] - 8'd1, 8'hFF}, {d[7:0] - 8'd1, 8'hFF});
      query_at(16'hFFFF, 16'h0000);
      query_at(16'h0000, 16'hFFFF);
      if (w < GRID_COLS) query_at({w[7:0], pick_frac()}, 16'h0000);
      if (d < GRID_ROWS) query_at(16'h0000, {d[7:0], pick_frac()});
      query_at({8'(pick_coord(w)), pick_frac()}, {8'(pick_coord(d)), pick_frac()});
    end
    wait_idle();
  endtask

  task automatic test_random(input int unsigned steps, input logic [31:0] w_set,
                             input logic [31:0] d_set, input int unsigned snd_pct,
                             input int unsigned rcv_pct);
    int unsigned w, d, k, x, z;
    wait_idle();
    cfg_write(REG_MAP_WIDTH, w_set);
    cfg_write(REG_MAP_DEPTH, d_set);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    w = eff_dim(cfg_width, GRID_COLS);
    d = eff_dim(cfg_depth, GRID_ROWS);
    repeat (steps) begin
      k = $urandom_range(99);
      x = pick_coord(w);
      z = pick_coord(d);
      if (k < 12) begin
        store_sample(pick_coord(GRID_COLS), pick_coord(GRID_ROWS),
                     16'($urandom_range(16'hFFFF)));
      end else if (k < 22 && (w < GRID_COLS || d < GRID_ROWS)) begin
        if (w < GRID_COLS && (d == GRID_ROWS || $urandom_range(1) == 1))
          query_at({8'($urandom_range(255, w)), 8'($urandom)}, 16'($urandom));
        else
          query_at(16'($urandom), {8'($urandom_range(255, d)), 8'($urandom)});
      end else begin
        query_at({x[7:0], pick_frac()}, {z[7:0], pick_frac()});
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    wait_idle();
    cfg_write(REG_MAP_WIDTH, 256);
    cfg_write(REG_MAP_DEPTH, 256);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 12; i++) query_at({8'(i), 8'h80}, {8'(i), 8'h40});
    wait_idle();
    // receiver stalls while the queue fills and the input stalls
    hold_left = 300;
    repeat (60) query_at({8'($urandom_range(11)), pick_frac()},
                         {8'($urandom_range(11)), pick_frac()});
    // sender pauses until the queue drains
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_random(380, 256, 256, 18, 80);
    test_random(380, $urandom_range(256, 2), $urandom_range(256, 2), 80, 18);
    test_random(380, 200, 7, 0, 0);
    test_backpressure();
    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
